/* hdl/jacobi_linear_solver_core_macros.svh */
// ----------------------------------------------------------------------------
// Jacobi solver assertion macros
// Shared concurrent assertion forms for the solver core.
// ----------------------------------------------------------------------------
`ifndef JACOBI_LINEAR_SOLVER_CORE_MACROS_SVH
`define JACOBI_LINEAR_SOLVER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define JLS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define JLS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/jls_pkg.sv */
// ----------------------------------------------------------------------------
// Jacobi solver package
// Sizes, address helpers and saturation shared by the solver core.
// ----------------------------------------------------------------------------
`default_nettype none

package jls_pkg;

   localparam int MAX_UNKNOWNS = 16;
   localparam int ROW_STRIDE   = MAX_UNKNOWNS + 1;
   localparam int STORE_DEPTH  = MAX_UNKNOWNS * ROW_STRIDE;

   // Counter holding 0..MAX_UNKNOWNS, index of one unknown, store addresses.
   localparam int CNT_W      = $clog2(MAX_UNKNOWNS + 1);
   localparam int IDX_W      = $clog2(MAX_UNKNOWNS);
   localparam int ADDR_W     = $clog2(STORE_DEPTH);
   localparam int POS_W      = $clog2(STORE_DEPTH + 1);
   localparam int EST_ADDR_W = IDX_W + 1;
   localparam int EST_DEPTH  = 2 * MAX_UNKNOWNS;

   // Field widths.
   localparam int ELEM_W = 16;
   localparam int Q_W    = 32;
   localparam int ACC_W  = 64;
   localparam int COEF_W = Q_W + ELEM_W;

   // Configuration register indexes.
   localparam logic CSR_SYSTEM_SIZE = 1'b0;
   localparam logic CSR_SWEEP_COUNT = 1'b1;

   typedef logic [CNT_W-1:0] cnt_type;

   // Store address of row r, column c.
   function automatic logic [ADDR_W-1:0] coef_addr(input cnt_type r, input cnt_type c);
      coef_addr = ADDR_W'(int'(r) * ROW_STRIDE + int'(c));
   endfunction

   // Size register clamped to 1..MAX_UNKNOWNS.
   function automatic cnt_type used_size(input logic [4:0] size);
      if (size == 5'd0) begin
         used_size = CNT_W'(1);
      end else if (int'(size) > MAX_UNKNOWNS) begin
         used_size = CNT_W'(MAX_UNKNOWNS);
      end else begin
         used_size = CNT_W'(size);
      end
   endfunction

   // Saturate a 64-bit signed value to signed 32 bits.
   function automatic logic signed [Q_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[Q_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

/* hdl/jls_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module jls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

/* hdl/jacobi_linear_solver_core.sv */
// ----------------------------------------------------------------------------
// Jacobi linear solver core
// Loads an augmented matrix, normalizes each row, runs Jacobi sweeps on one
// shared multiplier and reports every unknown in signed Q16.16.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Words
//  req_     in         valid / stall      one matrix element each
//  rsp_     out        valid / stall      one unknown each, last one marked
//  csr_     in         valid / ready      register index and write data
//
// A non-final element's row and column come from a repeated subtraction
// of n+1 from the load position.
// The final element starts the solve: each of the n*(n+1) normalized entries
// passes the 32-step divider unless its row has a zero pivot; each sweep then
// reads n coefficients per row, and the results go out after the last sweep.
// Reset is synchronous; the memories are not cleared.
// req_stall is high while an element is placed and after a final element until
// the last result is loaded; results wait in the output register on rsp_stall.
`default_nettype none

`include "jacobi_linear_solver_core_macros.svh"

module jacobi_linear_solver_core
   import jls_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_element_value,
   input  wire logic               req_final_element,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic              [3:0] rsp_unknown_index,
   output logic signed      [31:0] rsp_solution_value,
   output logic                    rsp_zero_pivot,
   output logic                    rsp_last_result,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic               csr_index,
   input  wire logic         [7:0] csr_wdata
);

   // Sequencer codes.
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_LDIV = 4'd1;
   localparam logic [3:0] ST_NDRD = 4'd2;
   localparam logic [3:0] ST_NDLT = 4'd3;
   localparam logic [3:0] ST_NARD = 4'd4;
   localparam logic [3:0] ST_NAWT = 4'd5;
   localparam logic [3:0] ST_NDIV = 4'd6;
   localparam logic [3:0] ST_NWR  = 4'd7;
   localparam logic [3:0] ST_SRD  = 4'd8;
   localparam logic [3:0] ST_SMUL = 4'd9;
   localparam logic [3:0] ST_SACC = 4'd10;
   localparam logic [3:0] ST_SBN  = 4'd11;
   localparam logic [3:0] ST_ORD  = 4'd12;
   localparam logic [3:0] ST_OWT  = 4'd13;

   // Control registers.
   logic [3:0]       state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [4:0]       size_ff, size_in;
   logic [7:0]       sweeps_cfg_ff, sweeps_cfg_in;
   logic             pivot_ff, pivot_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Working registers.
   logic [POS_W-1:0]         ld_c_ff, ld_c_in;
   cnt_type                  ld_r_ff, ld_r_in;
   cnt_type                  ld_n_ff, ld_n_in;
   logic signed [ELEM_W-1:0] elem_ff, elem_in;
   logic                     fin_ff, fin_in;
   cnt_type                  n_ff, n_in;
   logic [7:0]               sweeps_ff, sweeps_in;
   cnt_type                  i_ff, i_in;
   cnt_type                  j_ff, j_in;
   logic [7:0]               s_ff, s_in;
   logic signed [ELEM_W-1:0] d_ff, d_in;
   logic signed [ELEM_W-1:0] a_ff, a_in;
   logic [Q_W-1:0]           q_ff, q_in;
   logic [ELEM_W-1:0]        rem_ff, rem_in;
   logic                     neg_ff, neg_in;
   logic [4:0]               cnt_ff, cnt_in;
   logic                     bank_ff, bank_in;
   logic signed [ACC_W-1:0]  sum_ff, sum_in;
   logic signed [ACC_W-1:0]  prod_ff, prod_in;
   logic [3:0]               rsp_idx_ff, rsp_idx_in;
   logic signed [Q_W-1:0]    rsp_val_ff, rsp_val_in;
   logic                     rsp_zp_ff, rsp_zp_in;
   logic                     rsp_last_ff, rsp_last_in;

   // Memory ports.
   logic                  coef_we, coef_re;
   logic [ADDR_W-1:0]     coef_waddr, coef_raddr;
   logic [COEF_W-1:0]     coef_wdata, coef_rdata;
   logic                  est_we, est_re;
   logic [EST_ADDR_W-1:0] est_waddr, est_raddr;
   logic [Q_W-1:0]        est_wdata, est_rdata;

   // Helper values.
   logic                     req_take;
   cnt_type                  n_use;
   logic [POS_W-1:0]         total;
   logic signed [ELEM_W-1:0] raw;
   logic signed [Q_W-1:0]    norm_rd;
   logic [ELEM_W-1:0]        raw_mag;
   logic [ELEM_W-1:0]        d_mag;
   logic [ELEM_W:0]          rem_sh;
   logic [Q_W-1:0]           q_neg;
   logic [Q_W-1:0]           norm_wr;
   logic signed [ACC_W-1:0]  diff;
   logic                     out_load;

   // Coefficient store: normalized value above raw element.
   jls_ram #(.WIDTH(COEF_W), .DEPTH(STORE_DEPTH)) u_coef_ram (
      .clock (clock),
      .we    (coef_we),
      .waddr (coef_waddr),
      .wdata (coef_wdata),
      .re    (coef_re),
      .raddr (coef_raddr),
      .rdata (coef_rdata)
   );

   // Estimate store: two banks, one read and one written per sweep.
   jls_ram #(.WIDTH(Q_W), .DEPTH(EST_DEPTH)) u_est_ram (
      .clock (clock),
      .we    (est_we),
      .waddr (est_waddr),
      .wdata (est_wdata),
      .re    (est_re),
      .raddr (est_raddr),
      .rdata (est_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign n_use     = used_size(size_ff);
   assign total     = POS_W'(n_use) * (POS_W'(n_use) + POS_W'(1));

   assign raw     = coef_rdata[ELEM_W-1:0];
   assign norm_rd = coef_rdata[COEF_W-1:ELEM_W];
   assign raw_mag = raw[ELEM_W-1] ? ELEM_W'(-raw) : ELEM_W'(raw);
   assign d_mag   = d_ff[ELEM_W-1] ? ELEM_W'(-d_ff) : ELEM_W'(d_ff);
   assign rem_sh  = {rem_ff, q_ff[Q_W-1]};
   assign q_neg   = ~q_ff + Q_W'(1);
   assign norm_wr = neg_ff ? q_neg : (q_ff[Q_W-1] ? 32'h7FFF_FFFF : q_ff);
   assign diff    = ACC_W'(norm_rd) - sum_ff;
   assign prod_in = norm_rd * $signed(est_rdata);
   assign out_load = (state_ff == ST_OWT) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer and datapath next values.
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      size_in       = size_ff;
      sweeps_cfg_in = sweeps_cfg_ff;
      pivot_in      = pivot_ff;
      ld_c_in       = ld_c_ff;
      ld_r_in       = ld_r_ff;
      ld_n_in       = ld_n_ff;
      elem_in       = elem_ff;
      fin_in        = fin_ff;
      n_in          = n_ff;
      sweeps_in     = sweeps_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      s_in          = s_ff;
      d_in          = d_ff;
      a_in          = a_ff;
      q_in          = q_ff;
      rem_in        = rem_ff;
      neg_in        = neg_ff;
      cnt_in        = cnt_ff;
      bank_in       = bank_ff;
      sum_in        = sum_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_zp_in     = rsp_zp_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff;
      coef_we       = 1'b0;
      coef_waddr    = coef_addr(i_ff, j_ff);
      coef_wdata    = {norm_wr, a_ff};
      coef_re       = 1'b0;
      coef_raddr    = coef_addr(i_ff, j_ff);
      est_we        = 1'b0;
      est_waddr     = {1'b0, i_ff[IDX_W-1:0]};
      est_wdata     = norm_wr;
      est_re        = 1'b0;
      est_raddr     = {bank_ff, j_ff[IDX_W-1:0]};

      // Configuration writes.
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SYSTEM_SIZE: size_in       = csr_wdata[4:0];
            CSR_SWEEP_COUNT: sweeps_cfg_in = csr_wdata;
            default:         size_in       = size_ff;
         endcase
      end

      // The output register drains independently of the sequencer.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               elem_in = req_element_value;
               fin_in  = req_final_element;
               if (pos_ff < total) begin
                  ld_c_in  = pos_ff;
                  ld_r_in  = '0;
                  ld_n_in  = n_use;
                  state_in = ST_LDIV;
               end else if (req_final_element) begin
                  pos_in    = '0;
                  n_in      = n_use;
                  sweeps_in = sweeps_cfg_ff;
                  pivot_in  = 1'b0;
                  i_in      = '0;
                  state_in  = ST_NDRD;
               end
            end
         end

         // Row and column by repeated subtraction of the row length.
         ST_LDIV: begin
            if (ld_c_ff >= POS_W'(ld_n_ff) + POS_W'(1)) begin
               ld_c_in = ld_c_ff - POS_W'(ld_n_ff) - POS_W'(1);
               ld_r_in = ld_r_ff + CNT_W'(1);
            end else begin
               coef_we    = 1'b1;
               coef_waddr = coef_addr(ld_r_ff, CNT_W'(ld_c_ff));
               coef_wdata = {{Q_W{1'b0}}, elem_ff};
               if (fin_ff) begin
                  pos_in    = '0;
                  n_in      = n_use;
                  sweeps_in = sweeps_cfg_ff;
                  pivot_in  = 1'b0;
                  i_in      = '0;
                  state_in  = ST_NDRD;
               end else begin
                  pos_in   = pos_ff + POS_W'(1);
                  state_in = ST_IDLE;
               end
            end
         end

         // Fetch the diagonal of row i.
         ST_NDRD: begin
            coef_re    = 1'b1;
            coef_raddr = coef_addr(i_ff, i_ff);
            state_in   = ST_NDLT;
         end

         ST_NDLT: begin
            d_in = raw;
            if (raw == '0) begin
               pivot_in = 1'b1;
            end
            j_in     = '0;
            state_in = ST_NARD;
         end

         ST_NARD: begin
            coef_re  = 1'b1;
            state_in = ST_NAWT;
         end

         // Start the divider, or write zero for a zero pivot row.
         ST_NAWT: begin
            a_in   = raw;
            rem_in = '0;
            cnt_in = '0;
            if (d_ff == '0) begin
               q_in     = '0;
               neg_in   = 1'b0;
               state_in = ST_NWR;
            end else begin
               q_in     = {raw_mag, {ELEM_W{1'b0}}};
               neg_in   = raw[ELEM_W-1] ^ d_ff[ELEM_W-1];
               state_in = ST_NDIV;
            end
         end

         // One restoring division step per cycle.
         ST_NDIV: begin
            if (rem_sh >= {1'b0, d_mag}) begin
               rem_in = ELEM_W'(rem_sh - {1'b0, d_mag});
               q_in   = {q_ff[Q_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[ELEM_W-1:0];
               q_in   = {q_ff[Q_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = ST_NWR;
            end
         end

         // Store the normalized entry; the constant also seeds the estimate.
         ST_NWR: begin
            coef_we = 1'b1;
            if (j_ff == n_ff) begin
               est_we = 1'b1;
               if (i_ff == n_ff - CNT_W'(1)) begin
                  bank_in = 1'b0;
                  i_in    = '0;
                  j_in    = '0;
                  s_in    = '0;
                  sum_in  = '0;
                  state_in = (sweeps_ff == 8'd0) ? ST_ORD : ST_SRD;
               end else begin
                  i_in     = i_ff + CNT_W'(1);
                  state_in = ST_NDRD;
               end
            end else begin
               j_in     = j_ff + CNT_W'(1);
               state_in = ST_NARD;
            end
         end

         // Sweep: fetch a coefficient and estimate, skipping the diagonal; the constant needs no estimate.
         ST_SRD: begin
            if (j_ff == n_ff) begin
               coef_re  = 1'b1;
               state_in = ST_SBN;
            end else if (j_ff == i_ff) begin
               j_in = j_ff + CNT_W'(1);
            end else begin
               coef_re  = 1'b1;
               est_re   = 1'b1;
               state_in = ST_SMUL;
            end
         end

         ST_SMUL: begin
            state_in = ST_SACC;
         end

         // Floor to Q16.16 and accumulate.
         ST_SACC: begin
            sum_in   = sum_ff + (prod_ff >>> 16);
            j_in     = j_ff + CNT_W'(1);
            state_in = ST_SRD;
         end

         // New estimate of unknown i into the other bank.
         ST_SBN: begin
            est_we    = 1'b1;
            est_waddr = {~bank_ff, i_ff[IDX_W-1:0]};
            est_wdata = sat32(diff);
            j_in      = '0;
            sum_in    = '0;
            state_in  = ST_SRD;
            if (i_ff == n_ff - CNT_W'(1)) begin
               i_in    = '0;
               bank_in = ~bank_ff;
               if (s_ff == sweeps_ff - 8'd1) begin
                  state_in = ST_ORD;
               end else begin
                  s_in = s_ff + 8'd1;
               end
            end else begin
               i_in = i_ff + CNT_W'(1);
            end
         end

         ST_ORD: begin
            est_re    = 1'b1;
            est_raddr = {bank_ff, i_ff[IDX_W-1:0]};
            state_in  = ST_OWT;
         end

         // Hand one result to the output register when it is free.
         ST_OWT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = 4'(i_ff);
               rsp_val_in   = (pivot_ff || sweeps_ff == 8'd0) ? '0 : $signed(est_rdata);
               rsp_zp_in    = pivot_ff;
               rsp_last_in  = (i_ff == n_ff - CNT_W'(1));
               if (i_ff == n_ff - CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in     = i_ff + CNT_W'(1);
                  state_in = ST_ORD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_ff        <= '0;
         size_ff       <= 5'd4;
         sweeps_cfg_ff <= 8'd10;
         pivot_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         size_ff       <= size_in;
         sweeps_cfg_ff <= sweeps_cfg_in;
         pivot_ff      <= pivot_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      ld_c_ff     <= ld_c_in;
      ld_r_ff     <= ld_r_in;
      ld_n_ff     <= ld_n_in;
      elem_ff     <= elem_in;
      fin_ff      <= fin_in;
      n_ff        <= n_in;
      sweeps_ff   <= sweeps_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      s_ff        <= s_in;
      d_ff        <= d_in;
      a_ff        <= a_in;
      q_ff        <= q_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      bank_ff     <= bank_in;
      sum_ff      <= sum_in;
      prod_ff     <= prod_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_zp_ff   <= rsp_zp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_unknown_index  = rsp_idx_ff;
   assign rsp_solution_value = rsp_val_ff;
   assign rsp_zero_pivot     = rsp_zp_ff;
   assign rsp_last_result    = rsp_last_ff;

   // Checks on the sequencer.
   `JLS_ASSERT_NOW(a_div_nonzero, state_ff == ST_NDIV, d_ff != '0, "divider runs on zero pivot")
   `JLS_ASSERT_NOW(a_no_diag_mac, state_ff == ST_SMUL, j_ff != i_ff, "diagonal term multiplied")
   `JLS_ASSERT_NOW(a_load_row, state_ff == ST_LDIV, ld_r_ff < ld_n_ff, "load row beyond size")
   `JLS_ASSERT_NEXT(a_last_idle, out_load && i_ff == n_ff - CNT_W'(1),
                    state_ff == ST_IDLE, "sequencer not idle after last result")

endmodule

`default_nettype wire

/* tb/tb_jacobi_linear_solver_core.sv */
// ----------------------------------------------------------------------------
// Jacobi linear solver core testbench
// Streams augmented matrices into the core and predicts every reported unknown
// with an in-bench fixed-point Jacobi solver. Directed tests cover extremes,
// zero pivots, zero sweeps, size clamping, overlong and early matrices and
// size changes during loading. Random matrices then run under varied idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_jacobi_linear_solver_core
   import jls_pkg::*;
();

   // Matrix content styles.
   typedef enum int {MAT_DOMINANT, MAT_ANY, MAT_EXTREME, MAT_ZERO_DIAG} mat_kind_type;

   typedef struct {
      logic [3:0]         index;
      logic signed [31:0] value;
      logic               pivot;
      logic               last;
   } solution_word_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_element_value;
   logic               req_final_element;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [3:0]         rsp_unknown_index;
   logic signed [31:0] rsp_solution_value;
   logic               rsp_zero_pivot;
   logic               rsp_last_result;
   logic               csr_valid;
   logic               csr_ready;
   logic               csr_index;
   logic [7:0]         csr_wdata;

   // Shadow state of the core.
   logic [4:0]          size_reg;
   logic [7:0]          sweeps_reg;
   logic signed [31:0]  matrix_shadow [STORE_DEPTH];
   int                  load_index;
   solution_word_type   solution_q [$];

   int error_count;
   int send_gap_pct;
   int stall_pct;
   int hold_request;
   int hold_seen;
   int hold_left;
   int random_items;

   jacobi_linear_solver_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_element_value  (req_element_value),
      .req_final_element  (req_final_element),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_unknown_index  (rsp_unknown_index),
      .rsp_solution_value (rsp_solution_value),
      .rsp_zero_pivot     (rsp_zero_pivot),
      .rsp_last_result    (rsp_last_result),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Saturate to signed Q16.16.
   function automatic logic signed [31:0] clip_q16(input longint v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic int active_size();
      if (size_reg == 5'd0) begin
         return 1;
      end else if (int'(size_reg) > MAX_UNKNOWNS) begin
         return MAX_UNKNOWNS;
      end
      return int'(size_reg);
   endfunction

   // Solve the stored system and queue one word per unknown.
   task automatic solve_system();
      int                 n;
      longint             diag;
      longint             sum;
      logic               pivot;
      logic signed [31:0] norm [MAX_UNKNOWNS][ROW_STRIDE];
      logic signed [31:0] cur [MAX_UNKNOWNS];
      logic signed [31:0] nxt [MAX_UNKNOWNS];
      solution_word_type  w;
      n = active_size();
      pivot = 1'b0;
      for (int i = 0; i < n; i++) begin
         diag = matrix_shadow[i*ROW_STRIDE + i];
         if (diag == 0) pivot = 1'b1;
         for (int j = 0; j <= n; j++) begin
            if (diag == 0) begin
               norm[i][j] = '0;
            end else begin
               norm[i][j] = clip_q16((longint'(matrix_shadow[i*ROW_STRIDE + j]) * 65536)
                                     / diag);
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         cur[i] = norm[i][n];
         nxt[i] = '0;
      end
      for (int s = 0; s < int'(sweeps_reg); s++) begin
         for (int i = 0; i < n; i++) begin
            sum = 0;
            for (int j = 0; j < n; j++) begin
               if (j != i) sum += (longint'(norm[i][j]) * longint'(cur[j])) >>> 16;
            end
            nxt[i] = clip_q16(longint'(norm[i][n]) - sum);
         end
         for (int i = 0; i < n; i++) cur[i] = nxt[i];
      end
      for (int i = 0; i < n; i++) begin
         w.index = 4'(i);
         w.value = pivot ? 32'sd0 : nxt[i];
         w.pivot = pivot;
         w.last  = (i == n - 1);
         solution_q = {solution_q, w};
      end
   endtask

   // Place one accepted element; a final element starts the solve.
   task automatic accept_element(input logic signed [15:0] value, input logic fin);
      int n;
      n = active_size();
      if (load_index < n * (n + 1)) begin
         matrix_shadow[(load_index / (n + 1)) * ROW_STRIDE + load_index % (n + 1)] = value;
         load_index++;
      end
      if (fin) begin
         load_index = 0;
         solve_system();
      end
   endtask

   // Send one word on the element channel.
   task automatic send_element(input logic signed [15:0] value, input logic fin);
      logic taken;
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_element_value <= value;
      req_final_element <= fin;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      accept_element(value, fin);
   endtask

   // Wait until every solution has arrived and the core has settled.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (solution_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [7:0] value);
      logic taken;
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
      if (idx == CSR_SYSTEM_SIZE) size_reg = value[4:0];
      else sweeps_reg = value;
   endtask

   function automatic logic signed [15:0] pick_element(input mat_kind_type kind,
                                                       input logic on_diag);
      case (kind)
         MAT_DOMINANT: begin
            if (on_diag) begin
               return $urandom_range(1) ? 16'(16'sd4000 + $urandom_range(28767))
                                        : 16'(-16'sd4000 - $urandom_range(28768));
            end
            return 16'($signed($urandom_range(0, 400)) - 200);
         end
         MAT_EXTREME: begin
            return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         end
         MAT_ZERO_DIAG: begin
            if (on_diag && $urandom_range(1)) return 16'sd0;
            return 16'($urandom);
         end
         default: begin
            if (on_diag) return 16'($urandom) | 16'sd1;
            return 16'($urandom);
         end
      endcase
   endfunction

   // Stream count words of an augmented matrix laid out for n unknowns.
   task automatic send_matrix(input int n, input mat_kind_type kind, input int count);
      int row;
      int col;
      for (int k = 0; k < count; k++) begin
         row = k / (n + 1);
         col = k % (n + 1);
         send_element(pick_element(kind, row == col), k == count - 1);
      end
   endtask

   task automatic configure(input logic [7:0] size, input logic [7:0] sweeps);
      write_reg(CSR_SYSTEM_SIZE, size);
      write_reg(CSR_SWEEP_COUNT, sweeps);
   endtask

   // Fill the whole store once so that later short matrices read only written entries.
   // A size above the maximum acts as the maximum.
   task automatic test_full_store();
      configure(8'hFF, 8'd3);
      send_matrix(16, MAT_DOMINANT, 16 * 17);
   endtask

   task automatic test_extremes();
      configure(8'd2, 8'd255);
      send_matrix(2, MAT_DOMINANT, 6);
      configure(8'd3, 8'd7);
      send_matrix(3, MAT_EXTREME, 12);
      configure(8'd1, 8'd1);
      send_element(16'sh8000, 1'b0);
      send_element(16'sh7FFF, 1'b1);
   endtask

   task automatic test_zero_pivot();
      configure(8'd3, 8'd4);
      send_element(16'sd0, 1'b0);
      send_matrix(3, MAT_ANY, 11);
   endtask

   task automatic test_zero_sweeps();
      configure(8'd4, 8'd0);
      send_matrix(4, MAT_DOMINANT, 20);
   endtask

   // Size zero acts as one.
   task automatic test_size_limits();
      configure(8'd0, 8'd2);
      send_matrix(1, MAT_ANY, 2);
   endtask

   // Extra words past the matrix are dropped; an early final reuses old entries.
   task automatic test_overlong_and_early();
      configure(8'd2, 8'd5);
      send_matrix(2, MAT_DOMINANT, 9);
      send_matrix(2, MAT_DOMINANT, 3);
   endtask

   // Part of a matrix arrives under one size, the rest under another.
   task automatic test_size_change();
      configure(8'd3, 8'd6);
      for (int k = 0; k < 5; k++) begin
         send_element(pick_element(MAT_DOMINANT, (k % 4) == (k / 4)), 1'b0);
      end
      write_reg(CSR_SYSTEM_SIZE, 8'd2);
      send_matrix(2, MAT_DOMINANT, 4);
   endtask

   // Hold the result side off while more matrices keep arriving.
   task automatic test_backpressure();
      configure(8'd4, 8'd2);
      hold_request = hold_request + 1;
      send_matrix(4, MAT_DOMINANT, 20);
      send_matrix(4, MAT_ANY, 20);
   endtask

   task automatic test_random(input int items);
      int n;
      int count;
      int sent;
      sent = 0;
      while (sent < items) begin
         case ($urandom_range(19))
            0: configure(8'($urandom_range(17, 31)), 8'($urandom_range(0, 2)));
            1: configure(8'd0, 8'($urandom_range(0, 255)));
            2: configure(8'($urandom_range(6, 10)), 8'($urandom_range(0, 8)));
            default: configure(8'($urandom_range(1, 5)), 8'($urandom_range(0, 30)));
         endcase
         n = active_size();
         count = n * (n + 1);
         // Large systems end early on entries left by earlier matrices.
         if (n > 5) count = $urandom_range(1, 2 * (n + 1));
         else if ($urandom_range(9) == 0) count = $urandom_range(1, count + 4);
         case ($urandom_range(9))
            0: send_matrix(n, MAT_ANY, count);
            1: send_matrix(n, MAT_ZERO_DIAG, count);
            2: send_matrix(n, MAT_EXTREME, count);
            default: send_matrix(n, MAT_DOMINANT, count);
         endcase
         sent += count;
      end
   endtask

   // Receiver stall, with a long hold-off on each new request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_seen <= 0;
         hold_left <= 0;
      end else if (hold_request != hold_seen) begin
         hold_seen <= hold_request;
         hold_left <= 1500;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Sample the result channel mid-cycle, check it at the next edge.
   logic               rsp_taken;
   solution_word_type  rsp_word;
   always @(negedge clock) begin
      rsp_taken <= (rsp_valid === 1'b1) && (rsp_stall === 1'b0) && !reset;
      rsp_word.index <= rsp_unknown_index;
      rsp_word.value <= rsp_solution_value;
      rsp_word.pivot <= rsp_zero_pivot;
      rsp_word.last  <= rsp_last_result;
   end

   always @(posedge clock) begin
      solution_word_type want;
      if (rsp_taken) begin
         if (solution_q.size() == 0) begin
            $error("unexpected result word, index %0d", rsp_word.index);
            error_count++;
         end else begin
            want = solution_q.pop_front();
            if (rsp_word.index !== want.index) begin
               $error("unknown_index: expected %0d, got %0d", want.index, rsp_word.index);
               error_count++;
            end
            if (rsp_word.value !== want.value) begin
               $error("solution_value: expected %0d, got %0d", want.value, rsp_word.value);
               error_count++;
            end
            if (rsp_word.pivot !== want.pivot) begin
               $error("zero_pivot: expected %0b, got %0b", want.pivot, rsp_word.pivot);
               error_count++;
            end
            if (rsp_word.last !== want.last) begin
               $error("last_result: expected %0b, got %0b", want.last, rsp_word.last);
               error_count++;
            end
         end
      end
   end

   // Run limit.
   initial begin
      #40_000_000;
      $display("tb_jacobi_linear_solver_core: done, errors");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_element_value = '0;
      req_final_element = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_SYSTEM_SIZE;
      csr_wdata = '0;
      size_reg = 5'd4;
      sweeps_reg = 8'd10;
      load_index = 0;
      error_count = 0;
      hold_request = 0;
      send_gap_pct = 0;
      stall_pct = 0;
      random_items = 60;
      for (int k = 0; k < STORE_DEPTH; k++) matrix_shadow[k] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_full_store();
      test_extremes();
      test_zero_pivot();
      test_zero_sweeps();
      test_size_limits();
      test_overlong_and_early();
      test_size_change();
      test_backpressure();

      // Sender idles lightly while the receiver stalls heavily, then the reverse.
      send_gap_pct = 12;
      stall_pct = 83;
      test_random(random_items / 3);
      send_gap_pct = 83;
      stall_pct = 12;
      test_random(random_items / 3);
      send_gap_pct = 0;
      stall_pct = 0;
      test_random(random_items / 3);

      wait_idle();
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_jacobi_linear_solver_core: done, clean");
      end else begin
         $display("tb_jacobi_linear_solver_core: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
+incdir+hdl
hdl/jls_pkg.sv
hdl/jls_ram.sv
hdl/jacobi_linear_solver_core.sv
tb/tb_jacobi_linear_solver_core.sv
